// ===== rtl/suffix_automaton_engine_top_macros.svh =====
// assertion macros for the suffix automaton engine
`ifndef SUFFIX_AUTOMATON_ENGINE_TOP_MACROS_SVH
`define SUFFIX_AUTOMATON_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SAE_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define SAE_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define SAE_ASSERT_IMP(lbl, a, b, msg)
`define SAE_ASSERT_NXT(lbl, a, b, msg)
`endif

`endif

// ===== rtl/sae_pkg.sv =====
package sae_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_FINAL  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd2;
    localparam logic [1:0] ST_AFTER_FIN = 2'd3;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    localparam int OCC_W  = 13;
    localparam int BEST_W = 25;

    typedef enum logic [18:0] {
        S_INIT = 19'h00001,
        S_IDLE = 19'h00002,
        S_A0   = 19'h00004,
        S_A1   = 19'h00008,
        S_A2   = 19'h00010,
        S_A3   = 19'h00020,
        S_A4   = 19'h00040,
        S_A5   = 19'h00080,
        S_F0   = 19'h00100,
        S_F1   = 19'h00200,
        S_F2   = 19'h00400,
        S_F3   = 19'h00800,
        S_F4   = 19'h01000,
        S_F5   = 19'h02000,
        S_F6   = 19'h04000,
        S_Q0   = 19'h08000,
        S_Q1   = 19'h10000,
        S_Q2   = 19'h20000,
        S_OUT  = 19'h40000
    } state_t;

    typedef struct packed {
        logic clr;
        logic en;
    } best_ctl_t;

endpackage

// ===== rtl/sae_best.sv =====
module sae_best #(
    parameter int LW = 13
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sae_pkg::best_ctl_t     ctl,
    input  logic [LW-1:0]          len,
    input  logic [LW-1:0]          cnt,
    output logic [2*LW-1:0]        best
);

    logic [2*LW-1:0] prod_reg;
    logic            pv_reg;
    logic [2*LW-1:0] best_reg;

    // multiply stage then running maximum
    always_ff @(posedge clk)
    begin
        prod_reg <= len * cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            best_reg <= '0;
        end
        else if (ctl.clr)
        begin
            pv_reg   <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            pv_reg <= ctl.en && (cnt != LW'(1));
            if (pv_reg && (prod_reg > best_reg))
            begin
                best_reg <= prod_reg;
            end
        end
    end

    assign best = best_reg;

endmodule

// ===== rtl/suffix_automaton_engine_top.sv =====
// append walks the suffix links, with extra states when an edge exists or a clone is made;
// finalize clears and sums the length buckets, then walks the nodes
// throughput: one item at a time, the next item is taken in the cycle after a result is queued
// reset: sets up the root node in S_INIT, then ready; clear command does the same
// the result register lets the next item in while a result waits
`include "suffix_automaton_engine_top_macros.svh"

module suffix_automaton_engine_top #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // command, char_code, query_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status, found, occurrences, best_product
);

    localparam int NODES = 2 * MAX_LEN + 2;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int NW    = $clog2(NODES);
    localparam int XW    = $clog2(ALPHABET);
    localparam int RW    = ALPHABET * NW;

    localparam logic [NW-1:0] ROOT = NW'(1);

    // memories
    logic [LW-1:0] len_mem   [NODES];
    logic [NW-1:0] link_mem  [NODES];
    logic [LW-1:0] cnt_mem   [NODES];
    logic [RW-1:0] trans_mem [NODES];
    logic [NW-1:0] rank_mem  [NODES];
    logic [NW-1:0] bkt_mem   [MAX_LEN+1];

    logic          len_we, link_we, cnt_we, trans_we, rank_we, bkt_we;
    logic [NW-1:0] len_wa, link_wa, cnt_wa, trans_wa, rank_wa;
    logic [LW-1:0] bkt_wa, bkt_ra;
    logic [NW-1:0] len_ra, link_ra, cnt_ra, trans_ra, rank_ra;
    logic [LW-1:0] len_wd, cnt_wd, len_q, cnt_q;
    logic [NW-1:0] link_wd, rank_wd, bkt_wd, link_q, rank_q, bkt_q;
    logic [RW-1:0] trans_wd, trans_q;

    always_ff @(posedge clk)
    begin
        if (len_we)   len_mem[len_wa]     <= len_wd;
        if (link_we)  link_mem[link_wa]   <= link_wd;
        if (cnt_we)   cnt_mem[cnt_wa]     <= cnt_wd;
        if (trans_we) trans_mem[trans_wa] <= trans_wd;
        if (rank_we)  rank_mem[rank_wa]   <= rank_wd;
        if (bkt_we)   bkt_mem[bkt_wa]     <= bkt_wd;
        len_q   <= len_mem[len_ra];
        link_q  <= link_mem[link_ra];
        cnt_q   <= cnt_mem[cnt_ra];
        trans_q <= trans_mem[trans_ra];
        rank_q  <= rank_mem[rank_ra];
        bkt_q   <= bkt_mem[bkt_ra];
    end

    // control registers
    sae_pkg::state_t state_reg, state_next;
    logic [1:0]      ph_reg, ph_next;
    logic [NW-1:0]   i_reg, i_next;
    logic            query_reg, query_next;
    logic [XW-1:0]   x_reg, x_next;
    logic            xok_reg, xok_next;
    logic [NW-1:0]   nodes_reg, nodes_next;
    logic [NW-1:0]   last_reg, last_next;
    logic [LW-1:0]   last_len_reg, last_len_next;
    logic            ready_reg, ready_next;
    logic [NW-1:0]   walk_reg, walk_next;
    logic            wfail_reg, wfail_next;
    logic [NW-1:0]   p_reg, p_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [NW-1:0]   cl_reg, cl_next;
    logic [LW-1:0]   lenp_reg, lenp_next;
    logic [LW-1:0]   cu_reg, cu_next;
    logic [NW-1:0]   lnode_reg, lnode_next;
    logic [NW-1:0]   acc_reg, acc_next;
    logic [LW-1:0]   sl_reg, sl_next;
    logic [1:0]      rs_reg, rs_next;
    logic            rf_reg, rf_next;
    logic [LW-1:0]   ro_reg, ro_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic            out_found_reg, out_found_next;
    logic [sae_pkg::OCC_W-1:0]  out_occ_reg, out_occ_next;
    logic [sae_pkg::BEST_W-1:0] out_best_reg, out_best_next;

    sae_pkg::best_ctl_t bctl;
    logic [2*LW-1:0]    best;

    sae_best #(.LW(LW)) u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bctl),
        .len   (len_q),
        .cnt   (cnt_q),
        .best  (best)
    );

    logic [1:0]    in_cmd;
    logic [7:0]    in_char;
    logic [7:0]    in_off;
    logic          in_ok;
    logic [NW-1:0] slot;
    logic [NW-1:0] row_val;
    logic [RW-1:0] row_upd;
    logic [LW-1:0] len_slot;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_char = s_axis_tdata[9:2];
    assign in_off  = in_char - sae_pkg::CHAR_A;
    assign in_ok   = (in_char >= sae_pkg::CHAR_A) && (in_char <= sae_pkg::CHAR_Z)
                     && (in_off < 8'(ALPHABET));
    assign slot    = trans_q[x_reg*NW +: NW];
    assign len_slot = (len_q > LW'(MAX_LEN)) ? LW'(MAX_LEN) : len_q;

    always_comb
    begin
        row_upd = trans_q;
        row_upd[x_reg*NW +: NW] = row_val;
    end

    assign s_axis_tready = (state_reg == sae_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        i_next         = i_reg;
        query_next     = query_reg;
        x_next         = x_reg;
        xok_next       = xok_reg;
        nodes_next     = nodes_reg;
        last_next      = last_reg;
        last_len_next  = last_len_reg;
        ready_next     = ready_reg;
        walk_next      = walk_reg;
        wfail_next     = wfail_reg;
        p_next         = p_reg;
        cur_next       = cur_reg;
        q_next         = q_reg;
        cl_next        = cl_reg;
        lenp_next      = lenp_reg;
        cu_next        = cu_reg;
        lnode_next     = lnode_reg;
        acc_next       = acc_reg;
        sl_next        = sl_reg;
        rs_next        = rs_reg;
        rf_next        = rf_reg;
        ro_next        = ro_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next = out_found_reg;
        out_occ_next   = out_occ_reg;
        out_best_next  = out_best_reg;
        bctl           = '0;
        row_val        = cur_reg;
        len_we = 1'b0; link_we = 1'b0; cnt_we = 1'b0;
        trans_we = 1'b0; rank_we = 1'b0; bkt_we = 1'b0;
        len_wa = '0; link_wa = '0; cnt_wa = '0; trans_wa = '0; rank_wa = '0; bkt_wa = '0;
        len_wd = '0; link_wd = '0; cnt_wd = '0; trans_wd = '0; rank_wd = '0; bkt_wd = '0;
        len_ra = '0; link_ra = '0; cnt_ra = '0; trans_ra = '0; rank_ra = '0; bkt_ra = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sae_pkg::S_INIT:
            begin
                len_we = 1'b1;  len_wa = ROOT;
                link_we = 1'b1; link_wa = ROOT;
                cnt_we = 1'b1;  cnt_wa = ROOT;
                trans_we = 1'b1; trans_wa = ROOT;
                state_next = sae_pkg::S_IDLE;
            end
            sae_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next     = XW'(in_off);
                    xok_next   = in_ok;
                    query_next = (in_cmd == sae_pkg::CMD_QUERY);
                    rs_next    = sae_pkg::ST_OK;
                    rf_next    = 1'b0;
                    ro_next    = '0;
                    ph_next    = '0;
                    case (in_cmd)
                        sae_pkg::CMD_APPEND:
                        begin
                            if (ready_reg)
                            begin
                                rs_next = sae_pkg::ST_AFTER_FIN;
                                state_next = sae_pkg::S_OUT;
                            end
                            else if (!in_ok)
                            begin
                                rs_next = sae_pkg::ST_BAD_CHAR;
                                state_next = sae_pkg::S_OUT;
                            end
                            else if (last_len_reg >= LW'(MAX_LEN))
                            begin
                                rs_next = sae_pkg::ST_FULL;
                                state_next = sae_pkg::S_OUT;
                            end
                            else
                            begin
                                state_next = sae_pkg::S_A0;
                            end
                        end
                        sae_pkg::CMD_FINAL, sae_pkg::CMD_QUERY:
                        begin
                            if ((in_cmd == sae_pkg::CMD_QUERY) && s_axis_tdata[10])
                            begin
                                walk_next  = ROOT;
                                wfail_next = 1'b0;
                            end
                            if (!ready_reg)
                            begin
                                i_next = '0;
                                state_next = sae_pkg::S_F0;
                            end
                            else if (in_cmd == sae_pkg::CMD_QUERY)
                            begin
                                state_next = sae_pkg::S_Q0;
                            end
                            else
                            begin
                                state_next = sae_pkg::S_OUT;
                            end
                        end
                        sae_pkg::CMD_CLEAR:
                        begin
                            nodes_next    = ROOT;
                            last_next     = ROOT;
                            last_len_next = '0;
                            ready_next    = 1'b0;
                            walk_next     = ROOT;
                            wfail_next    = 1'b0;
                            bctl.clr      = 1'b1;
                            len_we = 1'b1;  len_wa = ROOT;
                            link_we = 1'b1; link_wa = ROOT;
                            cnt_we = 1'b1;  cnt_wa = ROOT;
                            trans_we = 1'b1; trans_wa = ROOT;
                            state_next = sae_pkg::S_OUT;
                        end
                        default:
                        begin
                            state_next = sae_pkg::S_OUT;
                        end
                    endcase
                end
            end
            // append: new node, then walk suffix links
            sae_pkg::S_A0:
            begin
                cur_next      = nodes_reg + NW'(1);
                nodes_next    = nodes_reg + NW'(1);
                last_next     = nodes_reg + NW'(1);
                last_len_next = last_len_reg + LW'(1);
                p_next        = last_reg;
                len_we = 1'b1; len_wa = nodes_reg + NW'(1); len_wd = last_len_reg + LW'(1);
                cnt_we = 1'b1; cnt_wa = nodes_reg + NW'(1); cnt_wd = LW'(1);
                trans_we = 1'b1; trans_wa = nodes_reg + NW'(1);
                trans_ra = last_reg; link_ra = last_reg; len_ra = last_reg;
                state_next = sae_pkg::S_A1;
            end
            sae_pkg::S_A1:
            begin
                if (slot == '0)
                begin
                    row_val  = cur_reg;
                    trans_we = 1'b1; trans_wa = p_reg; trans_wd = row_upd;
                    p_next   = link_q;
                    if (link_q == '0)
                    begin
                        link_we = 1'b1; link_wa = cur_reg; link_wd = ROOT;
                        state_next = sae_pkg::S_OUT;
                    end
                    else
                    begin
                        trans_ra = link_q; link_ra = link_q; len_ra = link_q;
                    end
                end
                else
                begin
                    q_next    = slot;
                    lenp_next = len_q + LW'(1);
                    len_ra = slot; link_ra = slot; trans_ra = slot;
                    state_next = sae_pkg::S_A2;
                end
            end
            sae_pkg::S_A2:
            begin
                if (lenp_reg == len_q)
                begin
                    link_we = 1'b1; link_wa = cur_reg; link_wd = q_reg;
                    state_next = sae_pkg::S_OUT;
                end
                else
                begin
                    cl_next    = nodes_reg + NW'(1);
                    nodes_next = nodes_reg + NW'(1);
                    len_we = 1'b1;  len_wa = nodes_reg + NW'(1);  len_wd = lenp_reg;
                    link_we = 1'b1; link_wa = nodes_reg + NW'(1); link_wd = link_q;
                    cnt_we = 1'b1;  cnt_wa = nodes_reg + NW'(1);
                    trans_we = 1'b1; trans_wa = nodes_reg + NW'(1); trans_wd = trans_q;
                    trans_ra = p_reg; link_ra = p_reg;
                    state_next = sae_pkg::S_A3;
                end
            end
            sae_pkg::S_A3:
            begin
                if (slot == q_reg)
                begin
                    row_val  = cl_reg;
                    trans_we = 1'b1; trans_wa = p_reg; trans_wd = row_upd;
                    p_next   = link_q;
                    if (link_q == '0)
                    begin
                        state_next = sae_pkg::S_A4;
                    end
                    else
                    begin
                        trans_ra = link_q; link_ra = link_q;
                    end
                end
                else
                begin
                    state_next = sae_pkg::S_A4;
                end
            end
            sae_pkg::S_A4:
            begin
                link_we = 1'b1; link_wa = q_reg; link_wd = cl_reg;
                state_next = sae_pkg::S_A5;
            end
            sae_pkg::S_A5:
            begin
                link_we = 1'b1; link_wa = cur_reg; link_wd = cl_reg;
                state_next = sae_pkg::S_OUT;
            end
            // finalize: clear buckets
            sae_pkg::S_F0:
            begin
                bkt_we = 1'b1; bkt_wa = i_reg[LW-1:0];
                if (i_reg == NW'(MAX_LEN))
                begin
                    i_next = NW'(1);
                    state_next = sae_pkg::S_F1;
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                end
            end
            // count lengths
            sae_pkg::S_F1:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        len_ra = i_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        sl_next = len_slot; bkt_ra = len_slot; ph_next = 2'd2;
                    end
                    default:
                    begin
                        bkt_we = 1'b1; bkt_wa = sl_reg; bkt_wd = bkt_q + NW'(1);
                        ph_next = 2'd0;
                        if (i_reg == nodes_reg)
                        begin
                            i_next = '0; acc_next = '0;
                            state_next = sae_pkg::S_F2;
                        end
                        else
                        begin
                            i_next = i_reg + NW'(1);
                        end
                    end
                endcase
            end
            // prefix sums
            sae_pkg::S_F2:
            begin
                if (ph_reg == 2'd0)
                begin
                    bkt_ra = i_reg[LW-1:0]; ph_next = 2'd1;
                end
                else
                begin
                    acc_next = acc_reg + bkt_q;
                    bkt_we = 1'b1; bkt_wa = i_reg[LW-1:0]; bkt_wd = acc_reg + bkt_q;
                    ph_next = 2'd0;
                    if (i_reg == NW'(MAX_LEN))
                    begin
                        i_next = NW'(1);
                        state_next = sae_pkg::S_F3;
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                    end
                end
            end
            // place nodes by length
            sae_pkg::S_F3:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        len_ra = i_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        sl_next = len_slot; bkt_ra = len_slot; ph_next = 2'd2;
                    end
                    default:
                    begin
                        rank_we = 1'b1; rank_wa = bkt_q; rank_wd = i_reg;
                        bkt_we = 1'b1; bkt_wa = sl_reg; bkt_wd = bkt_q - NW'(1);
                        ph_next = 2'd0;
                        if (i_reg == nodes_reg)
                        begin
                            if (nodes_reg < NW'(2))
                            begin
                                i_next = NW'(1);
                                bctl.clr = 1'b1;
                                state_next = sae_pkg::S_F5;
                            end
                            else
                            begin
                                state_next = sae_pkg::S_F4;
                            end
                        end
                        else
                        begin
                            i_next = i_reg + NW'(1);
                        end
                    end
                endcase
            end
            // push counts up the suffix links, longest first
            sae_pkg::S_F4:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        rank_ra = i_reg; ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        link_ra = rank_q; cnt_ra = rank_q; ph_next = 2'd2;
                    end
                    2'd2:
                    begin
                        lnode_next = link_q; cu_next = cnt_q; cnt_ra = link_q;
                        ph_next = 2'd3;
                    end
                    default:
                    begin
                        cnt_we = 1'b1; cnt_wa = lnode_reg; cnt_wd = cnt_q + cu_reg;
                        ph_next = 2'd0;
                        if (i_reg == NW'(2))
                        begin
                            i_next = NW'(1);
                            bctl.clr = 1'b1;
                            state_next = sae_pkg::S_F5;
                        end
                        else
                        begin
                            i_next = i_reg - NW'(1);
                        end
                    end
                endcase
            end
            // best length times count
            sae_pkg::S_F5:
            begin
                if (ph_reg == 2'd0)
                begin
                    len_ra = i_reg; cnt_ra = i_reg; ph_next = 2'd1;
                end
                else
                begin
                    bctl.en = 1'b1;
                    ph_next = 2'd0;
                    if (i_reg == nodes_reg)
                    begin
                        state_next = sae_pkg::S_F6;
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                    end
                end
            end
            sae_pkg::S_F6:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    ready_next = 1'b1;
                    state_next = query_reg ? sae_pkg::S_Q0 : sae_pkg::S_OUT;
                end
            end
            // query walk
            sae_pkg::S_Q0:
            begin
                if (!xok_reg)
                begin
                    rs_next = sae_pkg::ST_BAD_CHAR;
                    wfail_next = 1'b1;
                    state_next = sae_pkg::S_OUT;
                end
                else if (wfail_reg)
                begin
                    state_next = sae_pkg::S_OUT;
                end
                else
                begin
                    trans_ra = walk_reg;
                    state_next = sae_pkg::S_Q1;
                end
            end
            sae_pkg::S_Q1:
            begin
                if (slot == '0)
                begin
                    wfail_next = 1'b1;
                    state_next = sae_pkg::S_OUT;
                end
                else
                begin
                    walk_next = slot;
                    cnt_ra = slot;
                    state_next = sae_pkg::S_Q2;
                end
            end
            sae_pkg::S_Q2:
            begin
                rf_next = 1'b1;
                ro_next = cnt_q;
                state_next = sae_pkg::S_OUT;
            end
            sae_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rs_reg;
                    out_found_next  = rf_reg;
                    out_occ_next    = sae_pkg::OCC_W'(ro_reg);
                    out_best_next   = sae_pkg::BEST_W'(best);
                    state_next = sae_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sae_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sae_pkg::S_INIT;
            ph_reg        <= '0;
            nodes_reg     <= ROOT;
            last_reg      <= ROOT;
            last_len_reg  <= '0;
            ready_reg     <= 1'b0;
            walk_reg      <= ROOT;
            wfail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            nodes_reg     <= nodes_next;
            last_reg      <= last_next;
            last_len_reg  <= last_len_next;
            ready_reg     <= ready_next;
            walk_reg      <= walk_next;
            wfail_reg     <= wfail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        query_reg      <= query_next;
        x_reg          <= x_next;
        xok_reg        <= xok_next;
        p_reg          <= p_next;
        cur_reg        <= cur_next;
        q_reg          <= q_next;
        cl_reg         <= cl_next;
        lenp_reg       <= lenp_next;
        cu_reg         <= cu_next;
        lnode_reg      <= lnode_next;
        acc_reg        <= acc_next;
        sl_reg         <= sl_next;
        rs_reg         <= rs_next;
        rf_reg         <= rf_next;
        ro_reg         <= ro_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_occ_reg    <= out_occ_next;
        out_best_reg   <= out_best_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_best_reg, out_occ_reg, out_found_reg, out_status_reg};

    `SAE_ASSERT_NXT(a_node_grows, state_reg == sae_pkg::S_A0, nodes_reg == $past(nodes_reg) + NW'(1), "append did not add a node")
    `SAE_ASSERT_IMP(a_walk_after_fin, state_reg == sae_pkg::S_Q0, ready_reg, "query walk before counts were ready")
    `SAE_ASSERT_NXT(a_fin_rejects, s_axis_tvalid && s_axis_tready && ready_reg && (in_cmd == sae_pkg::CMD_APPEND), state_reg == sae_pkg::S_OUT, "append after finalize was not rejected")

endmodule

// ===== sim/tb_suffix_automaton_engine_top.sv =====
module tb_suffix_automaton_engine_top;

    localparam int MAX_LEN = 4096;
    localparam int ALPHA   = 26;
    localparam int NODES   = 2 * MAX_LEN + 2;
    localparam int ROOT    = 1;

    typedef struct {
        logic [1:0]                 status;
        logic                       found;
        logic [sae_pkg::OCC_W-1:0]  occ;
        logic [sae_pkg::BEST_W-1:0] best;
    } sam_result_t;

    class sam_scoreboard;
        int unsigned node_len[NODES];
        int unsigned node_link[NODES];
        int unsigned node_cnt[NODES];
        int unsigned len_rank[NODES];
        int unsigned len_bucket[MAX_LEN + 1];
        int unsigned trans[NODES * ALPHA];
        int unsigned used;
        int unsigned last;
        bit          counted;
        int unsigned walk;
        bit          walk_dead;
        longint unsigned best;
        sam_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (node_len[i])
            begin
                node_len[i] = 0;
                node_link[i] = 0;
                node_cnt[i] = 0;
                len_rank[i] = 0;
            end
            foreach (len_bucket[i]) len_bucket[i] = 0;
            foreach (trans[i]) trans[i] = 0;
            used = 1;
            last = ROOT;
            counted = 0;
            walk = ROOT;
            walk_dead = 0;
            best = 0;
        endfunction

        function int letter(logic [7:0] c);
            if (c >= sae_pkg::CHAR_A && c <= sae_pkg::CHAR_Z && (c - sae_pkg::CHAR_A) < ALPHA)
                return int'(c - sae_pkg::CHAR_A);
            return -1;
        endfunction

        function void extend(int x);
            int unsigned cur, p, q, cl;
            used++;
            cur = used;
            p = last;
            node_len[cur] = node_len[last] + 1;
            node_cnt[cur] = 1;
            node_link[cur] = 0;
            while (p != 0 && trans[p * ALPHA + x] == 0)
            begin
                trans[p * ALPHA + x] = cur;
                p = node_link[p];
            end
            if (p == 0)
            begin
                node_link[cur] = ROOT;
            end
            else
            begin
                q = trans[p * ALPHA + x];
                if (node_len[p] + 1 == node_len[q])
                begin
                    node_link[cur] = q;
                end
                else
                begin
                    used++;
                    cl = used;
                    node_len[cl] = node_len[p] + 1;
                    node_link[cl] = node_link[q];
                    for (int k = 0; k < ALPHA; k++)
                        trans[cl * ALPHA + k] = trans[q * ALPHA + k];
                    node_cnt[cl] = 0;
                    while (p != 0 && trans[p * ALPHA + x] == q)
                    begin
                        trans[p * ALPHA + x] = cl;
                        p = node_link[p];
                    end
                    node_link[q] = cl;
                    node_link[cur] = cl;
                end
            end
            last = cur;
        endfunction

        function void count_up();
            int unsigned n, s, u;
            longint unsigned prod;
            if (counted)
                return;
            n = used;
            foreach (len_bucket[i]) len_bucket[i] = 0;
            for (int i = 1; i <= n; i++) len_bucket[node_len[i]]++;
            for (int i = 1; i <= MAX_LEN; i++) len_bucket[i] += len_bucket[i - 1];
            for (int i = 1; i <= n; i++)
            begin
                s = node_len[i];
                len_rank[len_bucket[s]] = i;
                len_bucket[s]--;
            end
            for (int i = n; i >= 2; i--)
            begin
                u = len_rank[i];
                node_cnt[node_link[u]] += node_cnt[u];
            end
            best = 0;
            for (int i = 1; i <= n; i++)
            begin
                if (node_cnt[i] != 1)
                begin
                    prod = longint'(node_len[i]) * node_cnt[i];
                    if (prod > best)
                        best = prod;
                end
            end
            counted = 1;
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] ch, logic restart);
            sam_result_t r;
            int x;
            int unsigned nx;
            x = letter(ch);
            r.status = sae_pkg::ST_OK;
            r.found = 0;
            r.occ = 0;
            case (cmd)
                sae_pkg::CMD_APPEND:
                begin
                    if (counted) r.status = sae_pkg::ST_AFTER_FIN;
                    else if (x < 0) r.status = sae_pkg::ST_BAD_CHAR;
                    else if (node_len[last] >= MAX_LEN) r.status = sae_pkg::ST_FULL;
                    else extend(x);
                end
                sae_pkg::CMD_FINAL: count_up();
                sae_pkg::CMD_QUERY:
                begin
                    count_up();
                    if (restart)
                    begin
                        walk = ROOT;
                        walk_dead = 0;
                    end
                    if (x < 0)
                    begin
                        r.status = sae_pkg::ST_BAD_CHAR;
                        walk_dead = 1;
                    end
                    else if (!walk_dead)
                    begin
                        nx = trans[walk * ALPHA + x];
                        if (nx == 0)
                        begin
                            walk_dead = 1;
                        end
                        else
                        begin
                            walk = nx;
                            r.found = 1;
                            r.occ = node_cnt[walk][sae_pkg::OCC_W-1:0];
                        end
                    end
                end
                default: wipe();
            endcase
            r.best = best[sae_pkg::BEST_W-1:0];
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(logic [47:0] d);
            sam_result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected item", d, 0);
                return;
            end
            e = pending.pop_front();
            if (d[1:0] !== e.status) report("status", d[1:0], e.status);
            if (d[2] !== e.found) report("found", d[2], e.found);
            if (d[15:3] !== e.occ) report("occurrences", d[15:3], e.occ);
            if (d[40:16] !== e.best) report("best_product", d[40:16], e.best);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;

    sam_scoreboard sb = new();
    int hold_left = 0;
    bit rx_steady = 0;
    bit tx_steady = 0;

    suffix_automaton_engine_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 clk = ~clk;

    function int gap_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // receiver stalls
    int stall = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 0;
            hold_left--;
        end
        else if (stall > 0)
        begin
            m_axis_tready <= 0;
            stall--;
        end
        else
        begin
            m_axis_tready <= 1;
            if (!rx_steady && $urandom_range(0, 5) == 0)
                stall = gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata);
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic restart);
        int g;
        @(negedge clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {5'd0, restart, ch, cmd};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(cmd, ch, restart);
        g = tx_steady ? 0 : gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // stop offering, then wait for every result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function logic [7:0] pick_char(int span);
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom_range(0, 255));
        return sae_pkg::CHAR_A + 8'($urandom_range(0, span - 1));
    endfunction

    task automatic random_phase();
        int span, n;
        span = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) span = ALPHA;
        n = $urandom_range(1, 30);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        send_item(sae_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
        for (int i = 0; i < n; i++)
            send_item(sae_pkg::CMD_APPEND, pick_char(span), 1'($urandom));
        if ($urandom_range(0, 1) == 0)
            send_item(sae_pkg::CMD_FINAL, 8'($urandom), 1'($urandom));
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_item(sae_pkg::CMD_APPEND, pick_char(span), 1'($urandom));
                1: send_item(sae_pkg::CMD_FINAL, 8'($urandom), 1'($urandom));
                default: send_item(sae_pkg::CMD_QUERY, pick_char(span),
                                   $urandom_range(0, 3) == 0);
            endcase
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed
        send_item(sae_pkg::CMD_APPEND, "a", 0);
        send_item(sae_pkg::CMD_APPEND, "b", 1);
        send_item(sae_pkg::CMD_APPEND, "a", 0);
        send_item(sae_pkg::CMD_APPEND, "b", 0);
        send_item(sae_pkg::CMD_APPEND, "z", 0);
        send_item(sae_pkg::CMD_APPEND, 8'h60, 0);
        send_item(sae_pkg::CMD_APPEND, 8'h7b, 0);
        send_item(sae_pkg::CMD_APPEND, 8'hff, 0);
        send_item(sae_pkg::CMD_APPEND, 8'h00, 0);
        send_item(sae_pkg::CMD_QUERY, "a", 1);
        send_item(sae_pkg::CMD_QUERY, "b", 0);
        send_item(sae_pkg::CMD_QUERY, "a", 0);
        send_item(sae_pkg::CMD_QUERY, "a", 0);
        send_item(sae_pkg::CMD_QUERY, "b", 0);
        send_item(sae_pkg::CMD_QUERY, "b", 1);
        send_item(sae_pkg::CMD_QUERY, 8'h41, 1);
        send_item(sae_pkg::CMD_QUERY, "a", 0);
        send_item(sae_pkg::CMD_FINAL, 8'hff, 1);
        send_item(sae_pkg::CMD_APPEND, "a", 0);
        send_item(sae_pkg::CMD_CLEAR, 8'h00, 0);
        send_item(sae_pkg::CMD_QUERY, "a", 1);
        send_item(sae_pkg::CMD_APPEND, "a", 0);
        drain();

        // fill the input while results are held back
        send_item(sae_pkg::CMD_CLEAR, 8'h00, 0);
        for (int i = 0; i < 8; i++) send_item(sae_pkg::CMD_APPEND, "a", 0);
        send_item(sae_pkg::CMD_FINAL, 8'h00, 0);
        drain();
        hold_left = 400;
        tx_steady = 1;
        for (int i = 0; i < 30; i++) send_item(sae_pkg::CMD_QUERY, "a", i % 4 == 0);
        drain();

        for (int k = 0; k < 23; k++)
        begin
            random_phase();
            if ($urandom_range(0, 2) == 0) drain();
        end
        drain();

        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end
endmodule
